[rtl/core/tti_pkg.sv]
// package for the trilinear table interpolator: payload structs, register indexes,
// grid geometry constants and shared helpers. no dependencies.
package tti_pkg;

  localparam int unsigned EnergyPoints = 32;
  localparam int unsigned BaryonPoints = 32;
  localparam int unsigned ChargePoints = 32;
  localparam int unsigned FractionBits = 24;
  localparam int unsigned StepBits     = 16;
  localparam int unsigned NumVal       = 5;
  localparam int unsigned ValW         = 32;

  localparam int unsigned EW = $clog2(EnergyPoints);
  localparam int unsigned BW = $clog2(BaryonPoints);
  localparam int unsigned QW = $clog2(ChargePoints);
  // one bank per corner parity, each bank holds one eighth of the grid
  localparam int unsigned EHW = EW - 1;
  localparam int unsigned BHW = BW - 1;
  localparam int unsigned QHW = QW - 1;
  localparam int unsigned BankAw = EHW + BHW + QHW;
  localparam int unsigned BankDepth = (EnergyPoints / 2) * (BaryonPoints / 2) *
                                      (ChargePoints / 2);
  localparam int unsigned WordW = NumVal * ValW;

  // valid line length: multiply, bank read and three interpolation stages
  localparam int unsigned PipeDepth = 5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PtsW     = 6;

  localparam logic [CfgIdxW-1:0] RegInvEnergy = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInvBaryon = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInvCharge = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPtsEnergy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPtsBaryon = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPtsCharge = 3'd5;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdLookup = 1'b1;

  localparam logic signed [ValW-1:0] MinusOne = -(ValW'(1) << FractionBits);

  typedef struct packed {
    logic               cmd;
    logic [4:0]         write_index_energy;
    logic [4:0]         write_index_baryon;
    logic [4:0]         write_index_charge;
    logic signed [31:0] entry_pressure;
    logic signed [31:0] entry_temperature;
    logic signed [31:0] entry_mu_baryon;
    logic signed [31:0] entry_mu_strange;
    logic signed [31:0] entry_mu_charge;
    logic signed [31:0] energy_dens;
    logic signed [31:0] baryon_density;
    logic signed [31:0] charge_density;
  } in_beat_t;

  typedef struct packed {
    logic               out_of_range;
    logic signed [31:0] pressure;
    logic signed [31:0] temperature;
    logic signed [31:0] mu_baryon;
    logic signed [31:0] mu_strange;
    logic signed [31:0] mu_charge;
  } out_beat_t;

  typedef struct packed {
    logic [31:0]     inv_energy;
    logic [31:0]     inv_baryon;
    logic [31:0]     inv_charge;
    logic [PtsW-1:0] pts_energy;
    logic [PtsW-1:0] pts_baryon;
    logic [PtsW-1:0] pts_charge;
  } cfg_t;

  typedef logic [FractionBits-1:0] frac_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef val_t [NumVal-1:0] vals_t;

  // one linear step: a + round_half_up((b - a) * w / 2^F)
  function automatic val_t lerp(input val_t a, input val_t b, input frac_t w);
    logic signed [ValW:0]                d;
    logic signed [ValW+FractionBits+1:0] p;
    logic signed [ValW+1:0]              r;
    d = {a[ValW-1], a} - {b[ValW-1], b};
    d = -d;
    p = d * $signed({1'b0, w});
    p = p + ((ValW+FractionBits+2)'(1) << (FractionBits - 1));
    r = (ValW+2)'(p >>> FractionBits);
    return val_t'((ValW+2)'(a) + r);
  endfunction

endpackage

[rtl/core/tti_ram.sv]
// generic single-port-write, single-port-read ram with registered read data.
// no dependencies.
module tti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tti_locate.sv]
// coordinate scaling stage pair: multiply, then cell index and range check.
// depends on tti_pkg.
module tti_locate (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [31:0]      coord,
  input  logic [31:0]             inv,
  input  logic [tti_pkg::PtsW-1:0] pts,
  input  logic [tti_pkg::PtsW-1:0] limit,
  output logic [4:0]              idx,
  output tti_pkg::frac_t          frac,
  output logic                    bad
);
  import tti_pkg::*;

  logic [63:0]     prod_r, prod_nxt;
  logic            neg_r, neg_nxt;
  logic [PtsW-1:0] pts_r, pts_nxt;
  logic [23:0]     cell_idx;
  logic [PtsW-1:0] p_eff;

  // stage one: exact product, negative coordinate flag
  always_comb begin
    neg_nxt  = coord[31] && (inv != 32'd0);
    prod_nxt = coord[31] ? 64'd0 : 64'(unsigned'(coord)) * 64'(inv);
    pts_nxt  = (pts > limit) ? limit : pts;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      neg_r  <= neg_nxt;
      pts_r  <= pts_nxt;
    end
  end

  // stage two logic: cell select and upper edge check
  always_comb begin
    p_eff    = pts_r;
    cell_idx = prod_r[63:FractionBits+StepBits];
    bad      = neg_r || (p_eff < PtsW'(2)) || (cell_idx >= 24'(p_eff - PtsW'(1)));
    idx      = cell_idx[4:0];
    frac     = prod_r[FractionBits+StepBits-1:StepBits];
  end

endmodule

[rtl/core/tti_lerp_stage.sv]
// three interpolation stages (energy, baryon, charge) for all five values.
// depends on tti_pkg.
module tti_lerp_stage (
  input  logic                       clk,
  input  logic                       en,
  input  tti_pkg::vals_t [7:0]       corner,
  input  tti_pkg::frac_t             we,
  input  tti_pkg::frac_t             wb,
  input  tti_pkg::frac_t             wq,
  output tti_pkg::vals_t             result
);
  import tti_pkg::*;

  vals_t [3:0] e_r;
  vals_t [1:0] b_r;
  vals_t       q_r;
  frac_t       wb_r, wq_r, wq2_r;

  // corner order: bit0 energy, bit1 baryon, bit2 charge
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumVal; k++) begin
        for (int j = 0; j < 4; j++) begin
          e_r[j][k] <= lerp(corner[2*j][k], corner[2*j+1][k], we);
        end
        b_r[0][k] <= lerp(e_r[0][k], e_r[1][k], wb_r);
        b_r[1][k] <= lerp(e_r[2][k], e_r[3][k], wb_r);
        q_r[k]    <= lerp(b_r[0][k], b_r[1][k], wq2_r);
      end
      wb_r  <= wb;
      wq_r  <= wq;
      wq2_r <= wq_r;
    end
  end

  assign result = q_r;

endmodule

[rtl/core/trilinear_table_interpolator.sv]
// Trilinear table interpolator. A write beat stores one grid entry of five Q8.24 values;
// a lookup beat returns one result beat with the five values interpolated from the
// eight corners of the addressed cell, or out_of_range and -1.0 everywhere. One beat is
// taken every cycle while the pipeline does not stall; a lookup result passes through the
// scaling multiply register, one bank read register, three interpolation stages and then
// the output register. The multiply is 32x32 and the eight parity banks are read in
// parallel. The whole pipeline stalls only when the output register is full and not
// taken. Grid contents are undefined until written.
module trilinear_table_interpolator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tti_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tti_pkg::out_beat_t         out_data,
  input  logic                       cfg_we,
  input  logic [tti_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tti_pkg::CfgDataW-1:0] cfg_data
);
  import tti_pkg::*;

  cfg_t cfg_r;
  logic adv;
  logic [PipeDepth-1:0] vld_r;
  logic [PipeDepth-1:1] oor_r;
  logic oor_now;
  out_beat_t out_r;
  logic out_vld_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_energy <= 32'd65536;
      cfg_r.inv_baryon <= 32'd65536;
      cfg_r.inv_charge <= 32'd65536;
      cfg_r.pts_energy <= PtsW'(32);
      cfg_r.pts_baryon <= PtsW'(32);
      cfg_r.pts_charge <= PtsW'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        RegInvEnergy: cfg_r.inv_energy <= cfg_data;
        RegInvBaryon: cfg_r.inv_baryon <= cfg_data;
        RegInvCharge: cfg_r.inv_charge <= cfg_data;
        RegPtsEnergy: cfg_r.pts_energy <= cfg_data[PtsW-1:0];
        RegPtsBaryon: cfg_r.pts_baryon <= cfg_data[PtsW-1:0];
        RegPtsCharge: cfg_r.pts_charge <= cfg_data[PtsW-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // write path into the parity banks
  logic        wr_en;
  logic [EW-1:0] wie;
  logic [BW-1:0] wib;
  logic [QW-1:0] wiq;
  logic [WordW-1:0] wword;
  assign wie   = in_data.write_index_energy[EW-1:0];
  assign wib   = in_data.write_index_baryon[BW-1:0];
  assign wiq   = in_data.write_index_charge[QW-1:0];
  assign wr_en = in_valid && in_ready && (in_data.cmd == CmdWrite);
  assign wword = {in_data.entry_pressure, in_data.entry_temperature,
                  in_data.entry_mu_baryon, in_data.entry_mu_strange,
                  in_data.entry_mu_charge};

  // coordinate scaling
  logic [4:0] ie, ib, iq;
  frac_t fe, fb, fq;
  logic be, bb, bq;
  tti_locate u_loc_e (.clk, .en(adv), .coord(in_data.energy_dens),
    .inv(cfg_r.inv_energy), .pts(cfg_r.pts_energy), .limit(PtsW'(EnergyPoints)),
    .idx(ie), .frac(fe), .bad(be));
  tti_locate u_loc_b (.clk, .en(adv), .coord(in_data.baryon_density),
    .inv(cfg_r.inv_baryon), .pts(cfg_r.pts_baryon), .limit(PtsW'(BaryonPoints)),
    .idx(ib), .frac(fb), .bad(bb));
  tti_locate u_loc_q (.clk, .en(adv), .coord(in_data.charge_density),
    .inv(cfg_r.inv_charge), .pts(cfg_r.pts_charge), .limit(PtsW'(ChargePoints)),
    .idx(iq), .frac(fq), .bad(bq));
  assign oor_now = be || bb || bq;

  // valid and flag shift line: 0 = after multiply, 1 = after read,
  // 2 to 4 = after each interpolation stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PipeDepth-2:0], in_valid && (in_data.cmd == CmdLookup)};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor_r <= {oor_r[PipeDepth-2:1], oor_now};
    end
  end

  // weights travel with the read
  frac_t fe_r, fb_r, fq_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      fe_r <= fe; fb_r <= fb; fq_r <= fq;
    end
  end

  // corner read: bank (pe,pb,pq) holds entries whose index parities match
  logic [WordW-1:0] bank_q [8];
  vals_t [7:0] corner;
  logic [2:0] sel_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sel_r <= {iq[0], ib[0], ie[0]};
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    localparam logic [2:0] Par = 3'(g);
    logic [EW-1:0] ce;
    logic [BW-1:0] cb;
    logic [QW-1:0] cq;
    logic [BankAw-1:0] ra;
    // corner of this bank's parity at or after the low index
    assign ce = EW'(ie) + EW'(ie[0] ^ Par[0]);
    assign cb = BW'(ib) + BW'(ib[0] ^ Par[1]);
    assign cq = QW'(iq) + QW'(iq[0] ^ Par[2]);
    assign ra = {ce[EW-1:1], cb[BW-1:1], cq[QW-1:1]};
    tti_ram #(.Width(WordW), .Depth(BankDepth)) u_ram (
      .clk,
      .we   (wr_en && (wie[0] == Par[0]) && (wib[0] == Par[1]) && (wiq[0] == Par[2])),
      .waddr({wie[EW-1:1], wib[BW-1:1], wiq[QW-1:1]}),
      .wdata(wword),
      .re   (adv),
      .raddr(ra),
      .rdata(bank_q[g])
    );
  end

  // route banks back to corner order
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      for (int k = 0; k < NumVal; k++) begin
        corner[c][k] = bank_q[3'(c) ^ sel_r][(NumVal-1-k)*ValW +: ValW];
      end
    end
  end

  vals_t res;
  tti_lerp_stage u_lerp (.clk, .en(adv), .corner, .we(fe_r), .wb(fb_r), .wq(fq_r),
    .result(res));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[PipeDepth-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_of_range <= oor_r[PipeDepth-1];
      out_r.pressure    <= oor_r[PipeDepth-1] ? MinusOne : res[0];
      out_r.temperature <= oor_r[PipeDepth-1] ? MinusOne : res[1];
      out_r.mu_baryon   <= oor_r[PipeDepth-1] ? MinusOne : res[2];
      out_r.mu_strange  <= oor_r[PipeDepth-1] ? MinusOne : res[3];
      out_r.mu_charge   <= oor_r[PipeDepth-1] ? MinusOne : res[4];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
